// ===== rtl/crcfa_pkg.sv =====
// CRC-16/MODBUS frame engine: shared types, constants and CRC functions.
// Used by every module of the block; no dependencies.
package crcfa_pkg;

	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 1;
	localparam int FIFO_DEPTH  = 4;

	localparam logic [CFG_IDX_W-1:0] CFG_CHECK_MODE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HIGH_FIRST = 1'd1;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;

	localparam logic [15:0] NIB_TAB [16] = '{
		16'h0000, 16'hCC01, 16'hD801, 16'h1400,
		16'hF001, 16'h3C00, 16'h2800, 16'hE401,
		16'hA001, 16'h6C00, 16'h7800, 16'hB401,
		16'h5000, 16'h9C01, 16'h8801, 16'h4400
	};

	typedef enum logic [1:0] {
		K_DATA,
		K_LAST,
		K_CHECK
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  data;
		logic [15:0] crc;
		logic        ok;
		logic        high_first;
	} entry_t;

	typedef enum logic [1:0] {
		PH_DATA,
		PH_CRC_A,
		PH_CRC_B
	} phase_t;

	function automatic logic [15:0] crc_nib(logic [15:0] c, logic [3:0] n);
		return {4'h0, c[15:4]} ^ NIB_TAB[c[3:0]] ^ NIB_TAB[n];
	endfunction

	function automatic logic [15:0] crc_byte(logic [15:0] c, logic [7:0] b);
		return crc_nib(crc_nib(c, b[3:0]), b[7:4]);
	endfunction

endpackage

// ===== rtl/crcfa_if.sv =====
// Valid/ready channel interfaces for frame bytes in and results out.
// Depends on nothing.
interface crcfa_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       frame_last;
	modport source (output valid, data_byte, frame_last, input ready);
	modport sink (input valid, data_byte, frame_last, output ready);
endinterface

interface crcfa_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  out_byte;
	logic        is_crc_byte;
	logic        frame_end;
	logic        crc_ok;
	logic [15:0] crc_value;
	modport source (output valid, out_byte, is_crc_byte, frame_end, crc_ok, crc_value,
		input ready);
	modport sink (input valid, out_byte, is_crc_byte, frame_end, crc_ok, crc_value,
		output ready);
endinterface

// ===== rtl/crcfa_front.sv =====
// Front end: accepts frame bytes, runs the CRC and hold buffer, queues work entries.
// Depends on crcfa_pkg and crcfa_in_if.
module crcfa_front import crcfa_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	crcfa_in_if.sink   din,
	input  logic       check_mode,
	input  logic       high_first,
	input  logic       full,
	output logic       push,
	output entry_t     push_entry
);

	logic [15:0] crc_q;
	logic [7:0]  held0_q, held1_q;
	logic [1:0]  held_cnt_q;

	logic        accept;
	logic [7:0]  upd_in;
	logic [15:0] crc_upd;
	logic [15:0] crc_c;
	logic [7:0]  h0_n, h1_n;
	logic [1:0]  cnt_n;
	logic        ok;

	assign din.ready = !full;
	assign accept    = din.valid && !full;
	assign upd_in    = check_mode ? held0_q : din.data_byte;
	assign crc_upd   = crc_byte(crc_q, upd_in);

	always_comb begin
		if (held_cnt_q >= 2'd2) begin
			crc_c = crc_upd;
			h0_n  = held1_q;
			h1_n  = din.data_byte;
			cnt_n = 2'd2;
		end else if (held_cnt_q == 2'd1) begin
			crc_c = crc_q;
			h0_n  = held0_q;
			h1_n  = din.data_byte;
			cnt_n = 2'd2;
		end else begin
			crc_c = crc_q;
			h0_n  = din.data_byte;
			h1_n  = held1_q;
			cnt_n = 2'd1;
		end
		if (high_first)
			ok = (cnt_n == 2'd2) && (h0_n == crc_c[15:8]) && (h1_n == crc_c[7:0]);
		else
			ok = (cnt_n == 2'd2) && (h0_n == crc_c[7:0]) && (h1_n == crc_c[15:8]);
	end

	always_comb begin
		push                  = accept && (!check_mode || din.frame_last);
		push_entry.data       = din.data_byte;
		push_entry.high_first = high_first;
		if (check_mode) begin
			push_entry.kind = K_CHECK;
			push_entry.crc  = crc_c;
			push_entry.ok   = ok;
		end else begin
			push_entry.kind = din.frame_last ? K_LAST : K_DATA;
			push_entry.crc  = crc_upd;
			push_entry.ok   = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q      <= CRC_INIT;
			held0_q    <= 8'h00;
			held1_q    <= 8'h00;
			held_cnt_q <= 2'd0;
		end else if (accept) begin
			if (din.frame_last) begin
				crc_q      <= CRC_INIT;
				held0_q    <= 8'h00;
				held1_q    <= 8'h00;
				held_cnt_q <= 2'd0;
			end else if (check_mode) begin
				crc_q      <= crc_c;
				held0_q    <= h0_n;
				held1_q    <= h1_n;
				held_cnt_q <= cnt_n;
			end else begin
				crc_q <= crc_upd;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) held_cnt_q <= 2'd2)
		else $error("hold count out of range");
	assert property (@(posedge clk) disable iff (!arst_n)
		accept && din.frame_last |=> crc_q == CRC_INIT && held_cnt_q == 2'd0)
		else $error("frame state not cleared after last byte");
	assert property (@(posedge clk) disable iff (!arst_n)
		held_cnt_q == 2'd0 |-> held0_q == 8'h00 && held1_q == 8'h00)
		else $error("hold buffer not clear while empty");

endmodule

// ===== rtl/crcfa_fifo.sv =====
// Small register queue of work entries between front and back end.
// Depends on crcfa_pkg.
module crcfa_fifo import crcfa_pkg::*; #(
	parameter int DEPTH = FIFO_DEPTH
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t push_entry,
	input  logic   pop,
	output logic   full,
	output logic   empty,
	output entry_t head
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
	localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);

	entry_t        mem_q [DEPTH];
	logic [AW-1:0] wptr_q, rptr_q;
	logic [CW-1:0] count_q;
	logic          do_push, do_pop;

	assign full    = (count_q == DEPTH_C);
	assign empty   = (count_q == '0);
	assign head    = mem_q[rptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wptr_q] <= push_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_push)
				wptr_q <= (wptr_q == LAST_PTR) ? '0 : wptr_q + 1'b1;
			if (do_pop)
				rptr_q <= (rptr_q == LAST_PTR) ? '0 : rptr_q + 1'b1;
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !do_push)
				count_q <= count_q - 1'b1;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) count_q <= DEPTH_C)
		else $error("queue count overflow");
	assert property (@(posedge clk) disable iff (!arst_n)
		do_push && !do_pop |=> count_q == $past(count_q) + 1'b1)
		else $error("queue count did not track push");

endmodule

// ===== rtl/crcfa_back.sv =====
// Back end: expands queued entries into result beats behind an output register.
// Depends on crcfa_pkg and crcfa_out_if.
module crcfa_back import crcfa_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        empty,
	input  entry_t      head,
	output logic        pop,
	crcfa_out_if.source dout
);

	phase_t      ph_q, ph_n;
	logic        vld_q;
	logic [7:0]  byte_q;
	logic        isc_q, fe_q, ok_q;
	logic [15:0] crc_q;

	logic        load;
	logic [7:0]  byte_n;
	logic        isc_n, fe_n, ok_n;
	logic [7:0]  first_crc, second_crc;

	assign load       = !empty && (!vld_q || dout.ready);
	assign first_crc  = head.high_first ? head.crc[15:8] : head.crc[7:0];
	assign second_crc = head.high_first ? head.crc[7:0] : head.crc[15:8];

	always_comb begin
		ph_n = ph_q;
		pop  = 1'b0;
		if (load) begin
			if (head.kind == K_LAST) begin
				unique case (ph_q)
					PH_DATA:  ph_n = PH_CRC_A;
					PH_CRC_A: ph_n = PH_CRC_B;
					default: begin
						ph_n = PH_DATA;
						pop  = 1'b1;
					end
				endcase
			end else begin
				pop = 1'b1;
			end
		end
	end

	always_comb begin
		byte_n = head.data;
		isc_n  = 1'b0;
		fe_n   = 1'b0;
		ok_n   = 1'b0;
		unique case (head.kind)
			K_CHECK: begin
				byte_n = 8'h00;
				fe_n   = 1'b1;
				ok_n   = head.ok;
			end
			K_LAST: begin
				unique case (ph_q)
					PH_DATA: ;
					PH_CRC_A: begin
						byte_n = first_crc;
						isc_n  = 1'b1;
					end
					default: begin
						byte_n = second_crc;
						isc_n  = 1'b1;
						fe_n   = 1'b1;
					end
				endcase
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q  <= PH_DATA;
			vld_q <= 1'b0;
		end else begin
			ph_q <= ph_n;
			if (load)
				vld_q <= 1'b1;
			else if (dout.ready)
				vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q <= byte_n;
			isc_q  <= isc_n;
			fe_q   <= fe_n;
			ok_q   <= ok_n;
			crc_q  <= head.crc;
		end
	end

	assign dout.valid       = vld_q;
	assign dout.out_byte    = byte_q;
	assign dout.is_crc_byte = isc_q;
	assign dout.frame_end   = fe_q;
	assign dout.crc_ok      = ok_q;
	assign dout.crc_value   = crc_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		ph_q != PH_DATA |-> !empty && head.kind == K_LAST)
		else $error("CRC phase without an append entry at the head");
	assert property (@(posedge clk) disable iff (!arst_n)
		vld_q && dout.ready && isc_q && !fe_q |=> vld_q && isc_q && fe_q)
		else $error("second CRC byte did not follow the first");
	assert property (@(posedge clk) disable iff (!arst_n)
		vld_q && isc_q |-> !ok_q)
		else $error("pass flag set on an appended CRC byte");

endmodule

// ===== rtl/crc16_frame_append_check_core.sv =====
// CRC-16/MODBUS append/check frame engine, top level.
// A result beat passes through the work queue and the output register after its byte is accepted.
// Throughput: one byte per cycle while the queue is not full; an append-mode last byte holds the output stage for three
// beats, so back-to-back one-byte append frames fill the queue and stall the input.
// Reset (arst_n low, asynchronous): append mode, low byte first, CRC 0xFFFF, queue empty.
// Depends on crcfa_pkg, crcfa_if, crcfa_front, crcfa_fifo, crcfa_back.
module crc16_frame_append_check_core import crcfa_pkg::*; #(
	parameter int DEPTH = FIFO_DEPTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	crcfa_in_if.sink              din,
	crcfa_out_if.source           dout
);

	logic   check_mode_q, high_first_q;
	logic   full, empty, push, pop;
	entry_t push_entry, head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			check_mode_q <= 1'b0;
			high_first_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_CHECK_MODE: check_mode_q <= cfg_data[0];
				CFG_HIGH_FIRST: high_first_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	crcfa_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.din        (din),
		.check_mode (check_mode_q),
		.high_first (high_first_q),
		.full       (full),
		.push       (push),
		.push_entry (push_entry)
	);

	crcfa_fifo #(.DEPTH(DEPTH)) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.full       (full),
		.empty      (empty),
		.head       (head)
	);

	crcfa_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.empty  (empty),
		.head   (head),
		.pop    (pop),
		.dout   (dout)
	);

endmodule

// ===== dv/crc16_frame_append_check_core_tb.sv =====
// Testbench for crc16_frame_append_check_core: directed frames, then random append/check frames.
// Checks every result beat in order against its bitwise CRC-16/MODBUS model or pinned values.
// Depends on crcfa_pkg, crcfa_if and the core RTL.
module crc16_frame_append_check_core_tb;
	import crcfa_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic APPEND = 1'b0;
	localparam logic CHECK = 1'b1;
	localparam logic LO_FIRST = 1'b0;
	localparam logic HI_FIRST = 1'b1;
	localparam int RANDOM_ITEMS = 446;
	localparam int LONG_HOLD = 120;
	localparam int SETTLE_CYCLES = 6;
	localparam int CYCLE_LIMIT = 200000;

	typedef struct packed {
		logic [7:0]  data;
		logic        crc_flag;
		logic        end_flag;
		logic        ok;
		logic [15:0] crc;
	} crc_beat_t;

	typedef struct packed {
		logic        mode;
		logic        hf;
		logic [7:0]  data;
		logic        last;
		logic        pinned;
		logic        ok;
		logic [15:0] crc;
	} frame_row_t;

	localparam frame_row_t DIRECTED [24] = '{
		'{APPEND, LO_FIRST, 8'h00, 1'b0, 1'b0, 1'b0, 16'h0000},
		'{APPEND, LO_FIRST, 8'hFF, 1'b0, 1'b0, 1'b0, 16'h0000},
		'{APPEND, LO_FIRST, 8'hA5, 1'b1, 1'b0, 1'b0, 16'h0000},
		'{APPEND, HI_FIRST, 8'h80, 1'b1, 1'b0, 1'b0, 16'h0000},
		'{APPEND, HI_FIRST, 8'h01, 1'b0, 1'b0, 1'b0, 16'h0000},
		'{APPEND, HI_FIRST, 8'h7F, 1'b1, 1'b0, 1'b0, 16'h0000},
		'{CHECK, LO_FIRST, 8'h01, 1'b0, 1'b0, 1'b0, 16'h0000},
		'{CHECK, LO_FIRST, 8'h03, 1'b0, 1'b0, 1'b0, 16'h0000},
		'{CHECK, LO_FIRST, 8'h00, 1'b0, 1'b0, 1'b0, 16'h0000},
		'{CHECK, LO_FIRST, 8'h00, 1'b0, 1'b0, 1'b0, 16'h0000},
		'{CHECK, LO_FIRST, 8'h00, 1'b0, 1'b0, 1'b0, 16'h0000},
		'{CHECK, LO_FIRST, 8'h01, 1'b0, 1'b0, 1'b0, 16'h0000},
		'{CHECK, LO_FIRST, 8'h84, 1'b0, 1'b0, 1'b0, 16'h0000},
		'{CHECK, LO_FIRST, 8'h0A, 1'b1, 1'b1, 1'b1, 16'h0A84},
		'{CHECK, LO_FIRST, 8'h55, 1'b1, 1'b1, 1'b0, 16'hFFFF},
		'{CHECK, HI_FIRST, 8'hFF, 1'b0, 1'b0, 1'b0, 16'h0000},
		'{CHECK, HI_FIRST, 8'hFF, 1'b1, 1'b1, 1'b1, 16'hFFFF},
		'{CHECK, HI_FIRST, 8'h00, 1'b0, 1'b0, 1'b0, 16'h0000},
		'{CHECK, HI_FIRST, 8'h00, 1'b1, 1'b1, 1'b0, 16'hFFFF},
		'{APPEND, HI_FIRST, 8'h12, 1'b0, 1'b0, 1'b0, 16'h0000},
		'{CHECK, HI_FIRST, 8'h34, 1'b0, 1'b0, 1'b0, 16'h0000},
		'{CHECK, HI_FIRST, 8'h56, 1'b1, 1'b0, 1'b0, 16'h0000},
		'{CHECK, LO_FIRST, 8'h9A, 1'b0, 1'b0, 1'b0, 16'h0000},
		'{APPEND, LO_FIRST, 8'hBC, 1'b1, 1'b0, 1'b0, 16'h0000}
	};

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	crcfa_in_if din ();
	crcfa_out_if dout ();

	crc16_frame_append_check_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.din       (din),
		.dout      (dout)
	);

	logic cfg_mode = APPEND;
	logic cfg_hf = LO_FIRST;
	logic [15:0] run_crc = CRC_INIT;
	logic [7:0] held [2] = '{8'h00, 8'h00};
	logic [1:0] held_n = 2'd0;

	crc_beat_t owed [$];
	int in_count = 0;
	int out_count = 0;
	int mismatches = 0;
	int cycles = 0;
	bit calm = 1'b0;
	bit hold_req = 1'b0;
	bit pin_on = 1'b0;
	logic pin_ok = 1'b0;
	logic [15:0] pin_crc = 16'h0000;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [15:0] modbus_crc_step(logic [15:0] c, logic [7:0] b);
		logic [15:0] r;
		r = c ^ {8'h00, b};
		for (int i = 0; i < 8; i++)
			r = r[0] ? ((r >> 1) ^ 16'hA001) : (r >> 1);
		return r;
	endfunction

	function automatic void frame_restart();
		run_crc = CRC_INIT;
		held[0] = 8'h00;
		held[1] = 8'h00;
		held_n = 2'd0;
	endfunction

	function automatic void take_byte(logic [7:0] b, logic fl);
		crc_beat_t beat;
		logic [7:0] lo;
		logic [7:0] hi;
		logic good;
		if (cfg_mode == APPEND) begin
			run_crc = modbus_crc_step(run_crc, b);
			owed.push_back('{b, 1'b0, 1'b0, 1'b0, run_crc});
			if (fl) begin
				lo = run_crc[7:0];
				hi = run_crc[15:8];
				owed.push_back('{(cfg_hf == HI_FIRST) ? hi : lo, 1'b1, 1'b0, 1'b0, run_crc});
				owed.push_back('{(cfg_hf == HI_FIRST) ? lo : hi, 1'b1, 1'b1, 1'b0, run_crc});
				frame_restart();
			end
		end else begin
			if (held_n >= 2) begin
				run_crc = modbus_crc_step(run_crc, held[0]);
				held[0] = held[1];
				held[1] = b;
			end else begin
				held[held_n[0]] = b;
				held_n = held_n + 2'd1;
			end
			if (fl) begin
				lo = run_crc[7:0];
				hi = run_crc[15:8];
				if (cfg_hf == HI_FIRST)
					good = (held_n >= 2) && (held[0] == hi) && (held[1] == lo);
				else
					good = (held_n >= 2) && (held[0] == lo) && (held[1] == hi);
				beat = '{8'h00, 1'b0, 1'b1, good, run_crc};
				if (pin_on)
					beat = '{8'h00, 1'b0, 1'b1, pin_ok, pin_crc};
				owed.push_back(beat);
				frame_restart();
			end
		end
	endfunction

	task automatic flag_mismatch(input string msg);
		mismatches++;
		$display("mismatch @%0t: %s", $time, msg);
	endtask

	always @(posedge clk) begin : watch
		crc_beat_t want;
		if (arst_n) begin
			if (dout.valid && dout.ready) begin
				if (owed.size() == 0) begin
					flag_mismatch($sformatf("unexpected beat %h/%b/%b/%b/%h", dout.out_byte,
						dout.is_crc_byte, dout.frame_end, dout.crc_ok, dout.crc_value));
				end else begin
					want = owed.pop_front();
					if (dout.out_byte !== want.data || dout.is_crc_byte !== want.crc_flag ||
						dout.frame_end !== want.end_flag || dout.crc_ok !== want.ok ||
						dout.crc_value !== want.crc)
						flag_mismatch($sformatf("beat %0d got %h/%b/%b/%b/%h want %h/%b/%b/%b/%h",
							out_count, dout.out_byte, dout.is_crc_byte, dout.frame_end,
							dout.crc_ok, dout.crc_value, want.data, want.crc_flag,
							want.end_flag, want.ok, want.crc));
				end
				out_count <= out_count + 1;
			end
			if (din.valid && din.ready) begin
				take_byte(din.data_byte, din.frame_last);
				in_count <= in_count + 1;
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("crc16_frame_append_check_core regression: fail");
			$finish;
		end
	end

	function automatic int pick_gap();
		if (calm)
			return 0;
		return ($urandom_range(0, 2) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 1);
	endfunction

	initial begin : drain
		int gap;
		int seen;
		dout.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			gap = pick_gap();
			if (hold_req) begin
				hold_req = 1'b0;
				gap = LONG_HOLD;
			end
			if (gap != 0) begin
				dout.ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			dout.ready <= 1'b1;
			seen = out_count;
			do @(negedge clk); while (out_count == seen);
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic fl, input logic pinned,
		input logic ok, input logic [15:0] crc);
		int gap;
		int seen;
		gap = pick_gap();
		if (gap != 0) begin
			din.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		din.valid <= 1'b1;
		din.data_byte <= b;
		din.frame_last <= fl;
		pin_on = pinned;
		pin_ok = ok;
		pin_crc = crc;
		seen = in_count;
		do @(negedge clk); while (in_count == seen);
	endtask

	task automatic settle();
		din.valid <= 1'b0;
		while (owed.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_link_mode(input logic mode, input logic hf);
		cfg_we <= 1'b1;
		cfg_index <= CFG_CHECK_MODE;
		cfg_data <= mode;
		@(negedge clk);
		cfg_index <= CFG_HIGH_FIRST;
		cfg_data <= hf;
		@(negedge clk);
		cfg_we <= 1'b0;
		cfg_mode = mode;
		cfg_hf = hf;
	endtask

	initial begin : stimulus
		int phase;
		int sent;
		int frames;
		int flen;
		int kind;
		int k;
		logic mode;
		logic hf;
		logic [15:0] pc;
		logic [7:0] fbytes [$];
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_CHECK_MODE;
		cfg_data = '0;
		din.valid = 1'b0;
		din.data_byte = 8'h00;
		din.frame_last = 1'b0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (DIRECTED[i]) begin
			if (DIRECTED[i].mode != cfg_mode || DIRECTED[i].hf != cfg_hf) begin
				settle();
				set_link_mode(DIRECTED[i].mode, DIRECTED[i].hf);
			end
			send_byte(DIRECTED[i].data, DIRECTED[i].last, DIRECTED[i].pinned,
				DIRECTED[i].ok, DIRECTED[i].crc);
		end

		sent = 0;
		phase = 0;
		while (sent < RANDOM_ITEMS) begin
			settle();
			if (phase < 4) begin
				mode = phase[1];
				hf = phase[0];
			end else begin
				mode = 1'($urandom_range(0, 1));
				hf = 1'($urandom_range(0, 1));
			end
			set_link_mode(mode, hf);
			calm = (phase == 1) || ($urandom_range(0, 3) == 0);
			if (phase == 1)
				hold_req = 1'b1;
			frames = (phase == 1) ? 3 : $urandom_range(1, 6);
			repeat (frames) begin
				fbytes.delete();
				kind = $urandom_range(0, 9);
				if (mode == CHECK && kind < 7) begin
					pc = CRC_INIT;
					repeat ($urandom_range(0, 10)) begin
						fbytes.push_back(8'($urandom_range(0, 255)));
						pc = modbus_crc_step(pc, fbytes[$]);
					end
					if (hf == HI_FIRST) begin
						fbytes.push_back(pc[15:8]);
						fbytes.push_back(pc[7:0]);
					end else begin
						fbytes.push_back(pc[7:0]);
						fbytes.push_back(pc[15:8]);
					end
					// corrupt one bit of an otherwise good frame
					if (kind == 6) begin
						k = $urandom_range(0, fbytes.size() - 1);
						fbytes[k] ^= (8'h01 << $urandom_range(0, 7));
					end
				end else begin
					if (phase == 1)
						flen = 16;
					else if ($urandom_range(0, 7) == 0)
						flen = $urandom_range(13, 28);
					else
						flen = $urandom_range(1, 12);
					repeat (flen) fbytes.push_back(8'($urandom_range(0, 255)));
				end
				foreach (fbytes[j])
					send_byte(fbytes[j], j == fbytes.size() - 1, 1'b0, 1'b0, 16'h0000);
				sent += fbytes.size();
			end
			// leave a frame open across the next register write
			if ($urandom_range(0, 5) == 0) begin
				k = $urandom_range(1, 3);
				repeat (k) send_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0, 16'h0000);
				sent += k;
			end
			phase++;
		end

		calm = 1'b0;
		settle();
		if (mismatches == 0)
			$display("crc16_frame_append_check_core regression: pass");
		else
			$display("crc16_frame_append_check_core regression: fail");
		$finish;
	end

endmodule
